// File: rtl/pnt_pkg.sv
// ----------------------------------------------------------------------------
// Perlin noise turbulence package
// Shared types and constants for the gradient noise and turbulence pipeline.
// ----------------------------------------------------------------------------
package pnt_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int TABLE_AW    = 8;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = 3;
  localparam int GRAD_COPIES = 4;

  typedef enum logic [1:0] {
    MODE_LOAD_GRAD = 2'd0,
    MODE_LOAD_PERM = 2'd1,
    MODE_NOISE     = 2'd2,
    MODE_TURB      = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         index;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic [7:0]         perm_x;
    logic [7:0]         perm_y;
    logic [7:0]         perm_z;
    logic [23:0]        point_x;
    logic [23:0]        point_y;
    logic [23:0]        point_z;
    logic [3:0]         octaves;
  } in_t;

  typedef struct packed {
    logic signed [23:0] noise_value;
    logic [1:0]         kind_echo;
  } out_t;

  typedef struct packed {
    logic             valid;
    mode_t            mode;
    logic             first;
    logic             last;
    logic             zero;
    logic [OCT_W-1:0] shift;
  } ctl_t;

endpackage

// File: rtl/perlin_noise_turbulence_unit.sv
// ----------------------------------------------------------------------------
// Perlin noise turbulence unit
// Three-dimensional gradient noise with octave turbulence, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ channel (valid/stall) as one packed struct.
// Load items write one entry of the gradient or permutation tables and return
// a zero result. Noise items return the signed noise value in Q7.16.
// Turbulence items return the saturated absolute octave sum in Q.16.
// Every item gives exactly one result on the out_ channel, in order.
// The evaluation pipeline takes one octave pass per cycle while the output
// is not stalled: load and noise items take a single pass, turbulence items
// take one pass per octave (1 to 8), and no new item is accepted until the
// last pass of the previous item has issued. For a single pass the result
// is registered through stages A to G and then the output register; each
// additional octave adds one more pass ahead of it.
// Reset clears the pipeline valid bits and the output valid flag; the tables
// are undefined until loaded. When the receiver stalls with a result waiting,
// the whole pipeline holds and in_stall is raised; nothing is lost.
// ----------------------------------------------------------------------------
module perlin_noise_turbulence_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pnt_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pnt_pkg::out_t  out_data
);
  import pnt_pkg::*;

  localparam logic [17:0] ONE18   = 18'(1 << FRAC_BITS);
  localparam logic [17:0] THREE18 = 18'(3 << FRAC_BITS);
  localparam logic signed [37:0] SAT_MAX = 38'sd8388607;
  localparam logic signed [37:0] SAT_MIN = -38'sd8388608;

  logic en;
  logic a_last;

  ctl_t ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r, ctl_e_r, ctl_f_r, ctl_g_r;
  logic out_valid_r;
  out_t out_r;
  logic signed [37:0] acc_r;

  logic [OCT_W-1:0] oct_i_a_r, oct_end_a_r;
  logic [TABLE_AW-1:0] idx_a_r, idx_b_r;
  logic [47:0] grad_a_r, grad_b_r;
  logic [23:0] perm_a_r;
  logic [23:0] pnt_a_r [3];

  logic [7:0] pm [3][TABLE_SIZE];
  logic [47:0] gm [GRAD_COPIES][TABLE_SIZE];

  logic [7:0]  plo_b_r [3];
  logic [7:0]  phi_b_r [3];
  logic [15:0] t_b_r [3];
  logic [15:0] s_b_r [3];

  logic [47:0] gd_c_r [8];
  logic [15:0] t_c_r [3];
  logic [16:0] fd_c_r [3];

  logic signed [35:0] dsum_d_r [8];
  logic [16:0] wxy_d_r [4];
  logic [16:0] wz_d_r [2];

  logic signed [21:0] dfl_e_r [8];
  logic [16:0] w_e_r [8];

  logic signed [39:0] prod_f_r [8];
  logic signed [26:0] noise_g_r;

  logic [TABLE_AW-1:0] g_b [8];
  logic [16:0] fd_b [3];
  logic signed [35:0] dsum_c [8];
  logic [16:0] wxy_c [4];
  logic [16:0] w_d [8];
  logic signed [39:0] prod_e [8];
  logic signed [26:0] noise_f;

  logic signed [37:0] acc_nxt;
  logic [37:0] mag;
  logic [37:0] tsh;
  logic signed [23:0] res;

  logic take;
  logic [OCT_W-1:0] new_end;
  logic new_zero;

  assign en        = !(out_valid_r && out_stall);
  assign a_last    = (oct_i_a_r == oct_end_a_r);
  assign in_stall  = !en || (ctl_a_r.valid && !a_last);
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    new_zero = 1'b0;
    new_end  = '0;
    if (mode_t'(in_data.mode) == MODE_TURB) begin
      if (in_data.octaves == 4'd0) begin
        new_zero = 1'b1;
      end else if (in_data.octaves > 4'(MAX_OCTAVES)) begin
        new_end = OCT_W'(MAX_OCTAVES - 1);
      end else begin
        new_end = OCT_W'(in_data.octaves - 4'd1);
      end
    end
  end

  // Control path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r     <= '0;
      ctl_b_r     <= '0;
      ctl_c_r     <= '0;
      ctl_d_r     <= '0;
      ctl_e_r     <= '0;
      ctl_f_r     <= '0;
      ctl_g_r     <= '0;
      out_valid_r <= 1'b0;
      oct_i_a_r   <= '0;
      oct_end_a_r <= '0;
    end else if (en) begin
      if (ctl_a_r.valid && !a_last) begin
        oct_i_a_r     <= oct_i_a_r + 1'b1;
        ctl_a_r.first <= 1'b0;
        ctl_a_r.last  <= (oct_i_a_r + 1'b1 == oct_end_a_r);
        ctl_a_r.shift <= ctl_a_r.shift - 1'b1;
      end else if (in_valid) begin
        oct_i_a_r     <= '0;
        oct_end_a_r   <= new_end;
        ctl_a_r.valid <= 1'b1;
        ctl_a_r.mode  <= mode_t'(in_data.mode);
        ctl_a_r.first <= 1'b1;
        ctl_a_r.last  <= (new_end == '0);
        ctl_a_r.zero  <= new_zero;
        ctl_a_r.shift <= (mode_t'(in_data.mode) == MODE_TURB) ?
                         OCT_W'(MAX_OCTAVES - 1) : '0;
      end else begin
        ctl_a_r.valid <= 1'b0;
      end
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= ctl_d_r;
      ctl_f_r <= ctl_e_r;
      ctl_g_r <= ctl_f_r;
      out_valid_r <= ctl_g_r.valid && ctl_g_r.last;
    end
  end

  // Stage B: corner gradient indices and fade.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      g_b[k] = (k[2] ? phi_b_r[0] : plo_b_r[0]) ^
               (k[1] ? phi_b_r[1] : plo_b_r[1]) ^
               (k[0] ? phi_b_r[2] : plo_b_r[2]);
    end
    for (int d = 0; d < 3; d++) begin
      logic [33:0] fm;
      fm = s_b_r[d] * (THREE18 - {1'b0, t_b_r[d], 1'b0});
      fd_b[d] = fm[32:16];
    end
  end

  // Stage C: dot products and the x/y weight products.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic signed [17:0] ox, oy, oz;
      logic signed [33:0] px, py, pz;
      ox = k[2] ? $signed({2'b00, t_c_r[0]} - ONE18) : $signed({2'b00, t_c_r[0]});
      oy = k[1] ? $signed({2'b00, t_c_r[1]} - ONE18) : $signed({2'b00, t_c_r[1]});
      oz = k[0] ? $signed({2'b00, t_c_r[2]} - ONE18) : $signed({2'b00, t_c_r[2]});
      px = $signed(gd_c_r[k][47:32]) * ox;
      py = $signed(gd_c_r[k][31:16]) * oy;
      pz = $signed(gd_c_r[k][15:0]) * oz;
      dsum_c[k] = 36'(px) + 36'(py) + 36'(pz);
    end
    for (int j = 0; j < 4; j++) begin
      logic [16:0] wa, wb;
      logic [33:0] m;
      wa = j[1] ? fd_c_r[0] : 17'(ONE18 - {1'b0, fd_c_r[0]});
      wb = j[0] ? fd_c_r[1] : 17'(ONE18 - {1'b0, fd_c_r[1]});
      m = wa * wb;
      wxy_c[j] = m[32:16];
    end
  end

  // Stages D to F: corner weights, weighted dot products, noise sum.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic [33:0] m;
      m = wxy_d_r[k[2:1]] * wz_d_r[k[0]];
      w_d[k] = m[32:16];
      prod_e[k] = dfl_e_r[k] * $signed({1'b0, w_e_r[k]});
    end
  end

  always_comb begin
    logic signed [42:0] sum;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + 43'(prod_f_r[k]);
    end
    noise_f = sum[42:16];
  end

  // Stage G: octave accumulation and result formatting.
  always_comb begin
    acc_nxt = (ctl_g_r.first ? 38'sd0 : acc_r) +
              (ctl_g_r.zero ? 38'sd0 : (38'(noise_g_r) <<< ctl_g_r.shift));
    mag = acc_nxt[37] ? 38'(-acc_nxt) : 38'(acc_nxt);
    tsh = mag >> (MAX_OCTAVES - 1);
    unique case (ctl_g_r.mode)
      MODE_TURB: begin
        res = (tsh > 38'(SAT_MAX)) ? 24'sd8388607 : 24'(tsh);
      end
      MODE_NOISE: begin
        if (acc_nxt > SAT_MAX) begin
          res = 24'sd8388607;
        end else if (acc_nxt < SAT_MIN) begin
          res = -24'sd8388608;
        end else begin
          res = 24'(acc_nxt);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Data path and tables.
  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        idx_a_r    <= in_data.index;
        grad_a_r   <= {in_data.grad_x, in_data.grad_y, in_data.grad_z};
        perm_a_r   <= {in_data.perm_x, in_data.perm_y, in_data.perm_z};
        pnt_a_r[0] <= in_data.point_x;
        pnt_a_r[1] <= in_data.point_y;
        pnt_a_r[2] <= in_data.point_z;
      end else if (ctl_a_r.valid && !a_last) begin
        for (int d = 0; d < 3; d++) begin
          pnt_a_r[d] <= {pnt_a_r[d][22:0], 1'b0};
        end
      end

      idx_b_r  <= idx_a_r;
      grad_b_r <= grad_a_r;
      for (int d = 0; d < 3; d++) begin
        logic [TABLE_AW-1:0] cl;
        logic [31:0] sq;
        cl = pnt_a_r[d][23:16];
        sq = pnt_a_r[d][15:0] * pnt_a_r[d][15:0];
        plo_b_r[d] <= pm[d][cl];
        phi_b_r[d] <= pm[d][cl + 1'b1];
        t_b_r[d]   <= pnt_a_r[d][15:0];
        s_b_r[d]   <= sq[31:16];
      end
      if (ctl_a_r.valid && ctl_a_r.mode == MODE_LOAD_PERM) begin
        pm[0][idx_a_r] <= perm_a_r[23:16];
        pm[1][idx_a_r] <= perm_a_r[15:8];
        pm[2][idx_a_r] <= perm_a_r[7:0];
      end

      for (int k = 0; k < 8; k++) begin
        gd_c_r[k] <= gm[k / 2][g_b[k]];
      end
      if (ctl_b_r.valid && ctl_b_r.mode == MODE_LOAD_GRAD) begin
        for (int j = 0; j < GRAD_COPIES; j++) begin
          gm[j][idx_b_r] <= grad_b_r;
        end
      end
      t_c_r  <= t_b_r;
      fd_c_r <= fd_b;

      dsum_d_r  <= dsum_c;
      wxy_d_r   <= wxy_c;
      wz_d_r[0] <= 17'(ONE18 - {1'b0, fd_c_r[2]});
      wz_d_r[1] <= fd_c_r[2];

      for (int k = 0; k < 8; k++) begin
        dfl_e_r[k] <= dsum_d_r[k][35:14];
      end
      w_e_r <= w_d;

      prod_f_r  <= prod_e;
      noise_g_r <= noise_f;

      if (ctl_g_r.valid) begin
        acc_r <= acc_nxt;
      end
      if (ctl_g_r.valid && ctl_g_r.last) begin
        out_r.noise_value <= res;
        out_r.kind_echo   <= ctl_g_r.mode;
      end
    end
  end

`ifndef SYNTH
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ctl_a_r.valid)
    else $error("accepted transfer did not enter the pipeline");

  a_octave_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_a_r.valid && !a_last |-> in_stall)
    else $error("input accepted during an octave sequence");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(ctl_g_r) && $stable(acc_r))
    else $error("pipeline moved while the output was stalled");

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind_echo == MODE_LOAD_GRAD ||
                  out_data.kind_echo == MODE_LOAD_PERM)
    |-> out_data.noise_value == '0)
    else $error("load result is not zero");
`endif

endmodule
